/* rtl/rucsh_pkg.sv */
`default_nettype none
package rucsh_pkg;

  // number format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int UV_W      = 17;
  localparam int UV_FRAC   = 16;

  // dividend and quotient magnitude width of the slab divide
  localparam int NUM_W  = DATA_W + FRAC_BITS;
  // signed slab parameter
  localparam int T_W    = NUM_W + 1;
  // split of t for the partial products
  localparam int LO_W   = NUM_W / 2;
  localparam int HI_W   = NUM_W - LO_W;
  // t * |d| magnitude
  localparam int PROD_W = NUM_W + DATA_W;
  // signed offset floor(t * d / one)
  localparam int OFS_W  = PROD_W - FRAC_BITS + 2;
  // unsaturated hit point
  localparam int PT_W   = OFS_W + 1;
  // four times a texture coordinate
  localparam int UVV_W  = PT_W + 1;
  // signed origin plus or minus half
  localparam int SLAB_W = DATA_W + 2;

  // face axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] o;
    logic [2:0][DATA_W-1:0] d;
  } ray_t;

endpackage
`default_nettype wire

/* rtl/rucsh_ifs.sv */
`default_nettype none
interface rucsh_ray_if;
  import rucsh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic signed [DATA_W-1:0] origin_z;
  logic signed [DATA_W-1:0] dir_x;
  logic signed [DATA_W-1:0] dir_y;
  logic signed [DATA_W-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rucsh_hit_if;
  import rucsh_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] t_entry;
  logic [1:0]               face_axis;
  logic                     face_negative;
  logic signed [DATA_W-1:0] hit_x;
  logic signed [DATA_W-1:0] hit_y;
  logic signed [DATA_W-1:0] hit_z;
  logic [UV_W-1:0]          tex_u;
  logic [UV_W-1:0]          tex_v;

  modport source (output valid, hit, t_entry, face_axis, face_negative, hit_x, hit_y, hit_z,
                  tex_u, tex_v, input ready);
  modport sink   (input valid, hit, t_entry, face_axis, face_negative, hit_x, hit_y, hit_z,
                  tex_u, tex_v, output ready);
endinterface
`default_nettype wire

/* rtl/ray_unit_cube_slab_hit_top.sv */
`default_nettype none
// Slab test of a local-space ray against the unit cube from -0.5 to 0.5. One ray is
// taken every clock while the pipe is not stalled and each gives one result word, in
// order. After the input register come the six slab divides, which run as restoring
// dividers with one quotient bit per pipeline stage over the 48-bit dividend; after
// them come the signed entry and exit, the slab select, the t * d partial products,
// their sum and the hit point and texture stage. The whole pipe stalls as one while
// a finished word waits and a new ray is taken whenever the output stage is empty or
// being read. A miss returns a word with every field zero.
module ray_unit_cube_slab_hit_top (
  input  logic        clk,
  input  logic        rst,
  rucsh_ray_if.sink   ray_in,
  rucsh_hit_if.source hit_out
);
  import rucsh_pkg::*;

  localparam logic signed [SLAB_W-1:0] HALF_S  = SLAB_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PT_W-1:0]   HALF_P  = PT_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [UVV_W-1:0]  HALF_U  = UVV_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [UVV_W-1:0]  FOUR_U  = UVV_W'(1) <<< (FRAC_BITS + 2);
  localparam logic signed [PT_W-1:0]   PMAX    = PT_W'(32'h7FFF_FFFF);
  localparam logic signed [PT_W-1:0]   PMIN    = -PMAX - PT_W'(1);
  localparam logic [PROD_W:0]          ONE_M1  = (PROD_W+1)'((1 << FRAC_BITS) - 1);
  localparam logic [UV_W-1:0]          UV_ONE  = UV_W'(1) << UV_FRAC;

  logic adv;
  assign adv          = !hit_out.valid || hit_out.ready;
  assign ray_in.ready = adv;

  // input register
  logic s0_v;
  ray_t s0;
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= ray_in.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s0.o <= {ray_in.origin_z, ray_in.origin_y, ray_in.origin_x};
      s0.d <= {ray_in.dir_z, ray_in.dir_y, ray_in.dir_x};
    end
  end

  // slab numerator and divisor magnitudes
  logic [DATA_W-1:0] na_mag [3];
  logic [DATA_W-1:0] nb_mag [3];
  logic [DATA_W-1:0] d_mag  [3];
  always_comb begin
    logic signed [SLAB_W-1:0] oe;
    logic signed [SLAB_W-1:0] a;
    logic signed [SLAB_W-1:0] b;
    logic [DATA_W-1:0]        dv;
    for (int i = 0; i < 3; i++) begin
      oe        = SLAB_W'($signed(s0.o[i]));
      a         = -HALF_S - oe;
      b         = HALF_S - oe;
      na_mag[i] = a[SLAB_W-1] ? DATA_W'(-a) : a[DATA_W-1:0];
      nb_mag[i] = b[SLAB_W-1] ? DATA_W'(-b) : b[DATA_W-1:0];
      dv        = s0.d[i];
      d_mag[i]  = dv[DATA_W-1] ? -dv : dv;
    end
  end

  // slab divides
  logic [NUM_W-1:0] qa [3];
  logic [NUM_W-1:0] qb [3];
  for (genvar g = 0; g < 3; g++) begin : g_axis
    rucsh_div u_div_a (
      .clk (clk),
      .en  (adv),
      .num ({na_mag[g], {FRAC_BITS{1'b0}}}),
      .den (d_mag[g]),
      .quo (qa[g])
    );
    rucsh_div u_div_b (
      .clk (clk),
      .en  (adv),
      .num ({nb_mag[g], {FRAC_BITS{1'b0}}}),
      .den (d_mag[g]),
      .quo (qb[g])
    );
  end

  // ray delay alongside the dividers
  ray_t             dl   [NUM_W];
  logic [NUM_W-1:0] dl_v;
  always_ff @(posedge clk) begin
    if (rst) dl_v <= '0;
    else if (adv) dl_v <= {dl_v[NUM_W-2:0], s0_v};
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      dl[0] <= s0;
      for (int k = 1; k < NUM_W; k++) dl[k] <= dl[k-1];
    end
  end

  // signed entry and exit per axis
  logic                  s1_v;
  ray_t                  s1;
  logic signed [T_W-1:0] s1_en [3];
  logic signed [T_W-1:0] s1_ex [3];
  logic [2:0]            s1_dz;
  logic                  s1_miss;
  logic signed [T_W-1:0] en_c [3];
  logic signed [T_W-1:0] ex_c [3];
  logic [2:0]            dz_c;
  logic                  miss_c;
  always_comb begin
    logic signed [SLAB_W-1:0] oe;
    logic signed [T_W-1:0]    ta;
    logic signed [T_W-1:0]    tb;
    logic                     dn;
    ray_t                     r;
    r      = dl[NUM_W-1];
    miss_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      oe      = SLAB_W'($signed(r.o[i]));
      dn      = r.d[i][DATA_W-1];
      dz_c[i] = r.d[i] == '0;
      ta      = ((-HALF_S - oe < 0) != dn) ? -$signed({1'b0, qa[i]}) : $signed({1'b0, qa[i]});
      tb      = ((HALF_S - oe < 0) != dn) ? -$signed({1'b0, qb[i]}) : $signed({1'b0, qb[i]});
      en_c[i] = dn ? tb : ta;
      ex_c[i] = dn ? ta : tb;
      if (dz_c[i] && (oe < -HALF_S || oe > HALF_S)) miss_c = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (adv) s1_v <= dl_v[NUM_W-1];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= dl[NUM_W-1];
      s1_en   <= en_c;
      s1_ex   <= ex_c;
      s1_dz   <= dz_c;
      s1_miss <= miss_c;
    end
  end

  // largest entry, first axis wins a tie; smallest exit
  logic                  s2_v;
  ray_t                  s2;
  logic signed [T_W-1:0] s2_near;
  logic signed [T_W-1:0] s2_far;
  logic                  s2_have;
  logic [1:0]            s2_axis;
  logic                  s2_neg;
  logic                  s2_miss;
  logic signed [T_W-1:0] near_c;
  logic signed [T_W-1:0] far_c;
  logic                  have_c;
  logic [1:0]            axis_c;
  logic                  neg_c;
  always_comb begin
    near_c = '0;
    far_c  = '0;
    have_c = 1'b0;
    axis_c = AXIS_X;
    neg_c  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!s1_dz[i]) begin
        if (!have_c || s1_en[i] > near_c) begin
          near_c = s1_en[i];
          axis_c = 2'(i);
          neg_c  = !s1.d[i][DATA_W-1];
        end
        if (!have_c || s1_ex[i] < far_c) far_c = s1_ex[i];
        have_c = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (adv) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2      <= s1;
      s2_near <= near_c;
      s2_far  <= far_c;
      s2_have <= have_c;
      s2_axis <= axis_c;
      s2_neg  <= neg_c;
      s2_miss <= s1_miss;
    end
  end

  // hit decision and t * |d| partial products
  logic                     s3_v;
  ray_t                     s3;
  logic                     s3_hit;
  logic [NUM_W-1:0]         s3_t;
  logic [1:0]               s3_axis;
  logic                     s3_neg;
  logic [LO_W+DATA_W-1:0]   s3_pl [3];
  logic [HI_W+DATA_W-1:0]   s3_ph [3];
  logic                     hit_c;
  logic [LO_W+DATA_W-1:0]   pl_c [3];
  logic [HI_W+DATA_W-1:0]   ph_c [3];
  always_comb begin
    logic [DATA_W-1:0] dv;
    logic [DATA_W-1:0] dm;
    hit_c = s2_have && !s2_miss && !(s2_near > s2_far) && !s2_near[T_W-1];
    for (int i = 0; i < 3; i++) begin
      dv      = s2.d[i];
      dm      = dv[DATA_W-1] ? -dv : dv;
      pl_c[i] = (LO_W+DATA_W)'(s2_near[LO_W-1:0]) * (LO_W+DATA_W)'(dm);
      ph_c[i] = (HI_W+DATA_W)'(s2_near[NUM_W-1:LO_W]) * (HI_W+DATA_W)'(dm);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (adv) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3      <= s2;
      s3_hit  <= hit_c;
      s3_t    <= s2_near[NUM_W-1:0];
      s3_axis <= s2_axis;
      s3_neg  <= s2_neg;
      s3_pl   <= pl_c;
      s3_ph   <= ph_c;
    end
  end

  // floor(t * d / one) per axis
  logic                    s4_v;
  ray_t                    s4;
  logic                    s4_hit;
  logic [NUM_W-1:0]        s4_t;
  logic [1:0]              s4_axis;
  logic                    s4_neg;
  logic signed [OFS_W-1:0] s4_ofs [3];
  logic signed [OFS_W-1:0] ofs_c  [3];
  always_comb begin
    logic [PROD_W:0] mag;
    logic [PROD_W:0] up;
    for (int i = 0; i < 3; i++) begin
      mag = ((PROD_W+1)'(s3_ph[i]) << LO_W) + (PROD_W+1)'(s3_pl[i]);
      up  = mag + ONE_M1;
      if (s3.d[i][DATA_W-1]) ofs_c[i] = -$signed(OFS_W'(up >> FRAC_BITS));
      else ofs_c[i] = $signed(OFS_W'(mag >> FRAC_BITS));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (adv) s4_v <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4      <= s3;
      s4_hit  <= s3_hit;
      s4_t    <= s3_t;
      s4_axis <= s3_axis;
      s4_neg  <= s3_neg;
      s4_ofs  <= ofs_c;
    end
  end

  // four times a coordinate to unsigned Q1.16, clamped
  function automatic logic [UV_W-1:0] to_uv(input logic signed [UVV_W-1:0] val);
    logic [FRAC_BITS+UV_FRAC+1:0] ext;
    ext = {val[FRAC_BITS+1:0], {UV_FRAC{1'b0}}};
    if (val <= 0) to_uv = '0;
    else if (val >= FOUR_U) to_uv = UV_ONE;
    else to_uv = UV_W'(ext >> (FRAC_BITS + 2));
  endfunction

  function automatic logic [DATA_W-1:0] sat_pt(input logic signed [PT_W-1:0] val);
    if (val > PMAX) sat_pt = {1'b0, {(DATA_W-1){1'b1}}};
    else if (val < PMIN) sat_pt = {1'b1, {(DATA_W-1){1'b0}}};
    else sat_pt = val[DATA_W-1:0];
  endfunction

  // hit point and texture coordinates
  logic signed [PT_W-1:0]  p_c [3];
  logic signed [UVV_W-1:0] u_c;
  logic signed [UVV_W-1:0] v_c;
  logic [DATA_W-1:0]       t_sat;
  always_comb begin
    logic signed [UVV_W-1:0] px;
    logic signed [UVV_W-1:0] py;
    logic signed [UVV_W-1:0] pz;
    for (int i = 0; i < 3; i++) begin
      p_c[i] = PT_W'($signed(s4.o[i])) + PT_W'(s4_ofs[i]);
      if (2'(i) == s4_axis) p_c[i] = s4_neg ? -HALF_P : HALF_P;
    end
    px = UVV_W'(p_c[0]);
    py = UVV_W'(p_c[1]);
    pz = UVV_W'(p_c[2]);
    unique case (s4_axis)
      AXIS_X: begin
        u_c = -pz + HALF_U;
        v_c = s4_neg ? (-py + 3 * HALF_U) : (py + 5 * HALF_U);
      end
      AXIS_Y: begin
        u_c = px + 3 * HALF_U;
        v_c = s4_neg ? (-pz + HALF_U) : (pz + 5 * HALF_U);
      end
      AXIS_Z: begin
        u_c = px + 3 * HALF_U;
        v_c = s4_neg ? (py + 3 * HALF_U) : (-py + 7 * HALF_U);
      end
      default: begin
        u_c = '0;
        v_c = '0;
      end
    endcase
    t_sat = (|s4_t[NUM_W-1:DATA_W-1]) ? {1'b0, {(DATA_W-1){1'b1}}} : s4_t[DATA_W-1:0];
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) hit_out.valid <= 1'b0;
    else if (adv) hit_out.valid <= s4_v;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      hit_out.hit           <= s4_hit;
      hit_out.t_entry       <= s4_hit ? t_sat : '0;
      hit_out.face_axis     <= s4_hit ? s4_axis : AXIS_X;
      hit_out.face_negative <= s4_hit && s4_neg;
      hit_out.hit_x         <= s4_hit ? sat_pt(p_c[0]) : '0;
      hit_out.hit_y         <= s4_hit ? sat_pt(p_c[1]) : '0;
      hit_out.hit_z         <= s4_hit ? sat_pt(p_c[2]) : '0;
      hit_out.tex_u         <= s4_hit ? to_uv(u_c) : '0;
      hit_out.tex_v         <= s4_hit ? to_uv(v_c) : '0;
    end
  end

endmodule
`default_nettype wire

/* rtl/rucsh_div.sv */
`default_nettype none
module rucsh_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rucsh_pkg::NUM_W-1:0]    num,
  input  logic [rucsh_pkg::DATA_W-1:0]   den,
  output logic [rucsh_pkg::NUM_W-1:0]    quo
);
  import rucsh_pkg::*;

  // one quotient bit per stage, restoring
  logic [DATA_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0]  nq_r  [NUM_W];
  logic [DATA_W-1:0] den_r [NUM_W];
  logic [DATA_W-1:0] rem_next [NUM_W];
  logic [NUM_W-1:0]  nq_next  [NUM_W];
  logic [DATA_W-1:0] den_next [NUM_W];

  always_comb begin
    logic [DATA_W-1:0] r_in;
    logic [DATA_W-1:0] d_in;
    logic [NUM_W-1:0]  q_in;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;
    for (int k = 0; k < NUM_W; k++) begin
      if (k == 0) begin
        r_in = '0;
        q_in = num;
        d_in = den;
      end else begin
        r_in = rem_r[k-1];
        q_in = nq_r[k-1];
        d_in = den_r[k-1];
      end
      trial       = {r_in, q_in[NUM_W-1]};
      diff        = trial - {1'b0, d_in};
      ge          = trial >= {1'b0, d_in};
      rem_next[k] = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      nq_next[k]  = {q_in[NUM_W-2:0], ge};
      den_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_W; k++) begin
        rem_r[k] <= rem_next[k];
        nq_r[k]  <= nq_next[k];
        den_r[k] <= den_next[k];
      end
    end
  end

  assign quo = nq_r[NUM_W-1];

endmodule
`default_nettype wire
